// ===== rtl/core/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros shared by the interpolator RTL
// Two clocked implication forms, disabled while the active-low reset is asserted.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define BIP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define BIP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/bip_pkg.sv =====
// ---------------------------------------------------------------------------
// bip_pkg
// Shared types and constants of the breakpoint interpolator.
// ---------------------------------------------------------------------------
`default_nettype none

package bip_pkg;

    localparam int MAX_POINTS_DEF = 64;
    localparam int MAX_PROFILE    = 64;

    // Serial divider widths
    localparam int DIV_W = 34;
    localparam int DVS_W = 16;

    localparam logic [6:0] PC_RESET = 7'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_CLAMP = 2'd1;
    localparam logic [1:0] ST_BAD   = 2'd2;

    typedef enum logic [1:0] {
        OPC_WRITE   = 2'd0,
        OPC_QUERY   = 2'd1,
        OPC_PROFILE = 2'd2,
        OPC_RSVD    = 2'd3
    } t_opcode;

    typedef enum logic [4:0] {
        DP_NONE,
        DP_LOAD,
        DP_WRITE,
        DP_POS_INIT,
        DP_RD_XMAX,
        DP_MUL,
        DP_RD_X,
        DP_CHK_X,
        DP_RD_YCL,
        DP_CAP_CL,
        DP_RD_Y0,
        DP_RD_Y1,
        DP_PMUL,
        DP_QDIV,
        DP_QTAKE,
        DP_FIRST,
        DP_POS_DIV,
        DP_POS_TAKE,
        DP_EMIT_OK,
        DP_EMIT_BAD,
        DP_EMIT_Q,
        DP_EMIT_P
    } t_dp_op;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DECODE,
        S_RD_XMAX,
        S_MUL,
        S_SRD,
        S_SCHK,
        S_CL_RD,
        S_CL_CAP,
        S_Y0_RD,
        S_Y1_RD,
        S_PMUL,
        S_DIV_GO,
        S_DIV_W,
        S_SAMPLE,
        S_POS_DIV,
        S_POS_W,
        S_EMIT_OK,
        S_EMIT_BAD,
        S_EMIT_Q,
        S_EMIT_P
    } t_state;

    typedef struct packed {
        t_opcode opcode;
        logic    bad_idx;
        logic    bad_cnt;
        logic    above;
        logic    i_zero;
        logic    i_last;
        logic    div_done;
        logic    k_zero;
        logic    k_last;
        logic    out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

// ===== rtl/core/breakpoint_interpolator_profile.sv =====
// ---------------------------------------------------------------------------
// breakpoint_interpolator_profile
// Piecewise-linear interpolator over a breakpoint table, with a profile mode.
// ---------------------------------------------------------------------------
//
//  channel   dir  handshake                   payload
//  s_*       in   s_tvalid / s_tready         tdata: index, x, y, position,
//                                             sample count; tuser: opcode
//  m_*       out  m_tvalid / m_tready         tdata: y, rising, status; tlast
//  cfg       in   i_cfg_valid / o_cfg_ready   point count, always ready
//
//  Write item: decode and memory write, plus any wait on the result register.
//  Query: the time grows with s, the breakpoints scanned; the memory read
//  per breakpoint and the serial divider set it.
//  Profile with count n: each of the n+1 samples repeats the query search, and
//  a second divider pass computes each sample position.
//  Reset is synchronous, active low; the point count returns to 2, the
//  breakpoint memories keep their contents. A stalled m_tready holds the
//  sequencer only when the next result is ready to go.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module breakpoint_interpolator_profile #(
    parameter int MAX_POINTS = bip_pkg::MAX_POINTS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // tdata: point_index[5:0], point_x[21:6], point_y[37:22],
    //        position[53:38], sample_count[60:54], zero [63:61]
    input  wire logic [63:0] s_tdata,
    // tuser: opcode[1:0]
    input  wire logic [1:0]  s_tuser,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // tdata: y_result[15:0], rising[16], status[18:17], zero [23:19]
    output logic [23:0]      m_tdata,
    output logic             m_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [6:0]  i_cfg_data
);

    bip_pkg::t_dp_op  op;
    bip_pkg::t_dp_sts sts;

    // Point count takes a write on any cycle
    assign o_cfg_ready = 1'b1;

    bip_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_tvalid),
        .o_in_ready (s_tready),
        .i_sts      (sts),
        .o_op       (op)
    );

    bip_dp #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (op),
        .o_sts       (sts),
        .i_in_data   (s_tdata),
        .i_in_user   (s_tuser),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (m_tvalid),
        .i_out_ready (m_tready),
        .o_out_data  (m_tdata),
        .o_out_last  (m_tlast)
    );

    // An accepted item keeps the sequencer busy on the next cycle
    `BIP_ASSERT_NEXT(a_busy_after_take, i_clk, i_rst_n, s_tvalid && s_tready, !s_tready, "item taken while busy")
    // Profile bits never come with the error status
    `BIP_ASSERT_SAME(a_rise_not_bad, i_clk, i_rst_n, m_tvalid && m_tdata[16], m_tdata[18:17] != bip_pkg::ST_BAD, "rising bit on error")
    // A nonzero value only comes from a query, which is always last
    `BIP_ASSERT_SAME(a_value_last, i_clk, i_rst_n, m_tvalid && (m_tdata[15:0] != 16'h0000), m_tlast, "value without last")

endmodule

`default_nettype wire

// ===== rtl/core/bip_div.sv =====
// ---------------------------------------------------------------------------
// bip_div
// Restoring unsigned divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module bip_div (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [bip_pkg::DIV_W-1:0]  i_dividend,
    input  wire logic [bip_pkg::DVS_W-1:0]  i_divisor,
    output logic                            o_done,
    output logic [bip_pkg::DIV_W-1:0]       o_quo,
    output logic [bip_pkg::DVS_W-1:0]       o_rem
);

    localparam int CNT_W = $clog2(bip_pkg::DIV_W + 1);

    logic [bip_pkg::DIV_W-1:0] r_quo, n_quo;
    logic [bip_pkg::DVS_W-1:0] r_rem, n_rem, r_dvs;
    logic [CNT_W-1:0]          r_cnt;
    logic                      r_busy, r_done;
    logic [bip_pkg::DVS_W:0]   trial, diff;
    logic                      ge;

    always_comb begin
        trial = {r_rem, r_quo[bip_pkg::DIV_W-1]};
        diff  = trial - {1'b0, r_dvs};
        ge    = (trial >= {1'b0, r_dvs});
        n_rem = ge ? diff[bip_pkg::DVS_W-1:0] : trial[bip_pkg::DVS_W-1:0];
        n_quo = {r_quo[bip_pkg::DIV_W-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(bip_pkg::DIV_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

// ===== rtl/core/bip_ctrl.sv =====
// ---------------------------------------------------------------------------
// bip_ctrl
// Sequencer: steps the datapath through write, query and profile items.
// ---------------------------------------------------------------------------
`default_nettype none

module bip_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire bip_pkg::t_dp_sts i_sts,
    output bip_pkg::t_dp_op       o_op
);

    bip_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bip_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_op       = bip_pkg::DP_NONE;
        o_in_ready = 1'b0;
        case (r_state)
            bip_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_op    = bip_pkg::DP_LOAD;
                    n_state = bip_pkg::S_DECODE;
                end
            end
            bip_pkg::S_DECODE: begin
                case (i_sts.opcode)
                    bip_pkg::OPC_WRITE: begin
                        if (i_sts.bad_idx) begin
                            n_state = bip_pkg::S_EMIT_BAD;
                        end else begin
                            o_op    = bip_pkg::DP_WRITE;
                            n_state = bip_pkg::S_EMIT_OK;
                        end
                    end
                    bip_pkg::OPC_QUERY: begin
                        o_op    = bip_pkg::DP_POS_INIT;
                        n_state = bip_pkg::S_RD_XMAX;
                    end
                    bip_pkg::OPC_PROFILE: begin
                        if (i_sts.bad_cnt) begin
                            n_state = bip_pkg::S_EMIT_BAD;
                        end else begin
                            o_op    = bip_pkg::DP_POS_INIT;
                            n_state = bip_pkg::S_RD_XMAX;
                        end
                    end
                    default: n_state = bip_pkg::S_EMIT_BAD;
                endcase
            end
            bip_pkg::S_RD_XMAX: begin
                o_op    = bip_pkg::DP_RD_XMAX;
                n_state = bip_pkg::S_MUL;
            end
            bip_pkg::S_MUL: begin
                o_op    = bip_pkg::DP_MUL;
                n_state = bip_pkg::S_SRD;
            end
            bip_pkg::S_SRD: begin
                o_op    = bip_pkg::DP_RD_X;
                n_state = bip_pkg::S_SCHK;
            end
            bip_pkg::S_SCHK: begin
                o_op = bip_pkg::DP_CHK_X;
                if (i_sts.above) begin
                    n_state = i_sts.i_zero ? bip_pkg::S_CL_RD : bip_pkg::S_Y0_RD;
                end else begin
                    n_state = i_sts.i_last ? bip_pkg::S_CL_RD : bip_pkg::S_SRD;
                end
            end
            bip_pkg::S_CL_RD: begin
                o_op    = bip_pkg::DP_RD_YCL;
                n_state = bip_pkg::S_CL_CAP;
            end
            bip_pkg::S_CL_CAP: begin
                o_op    = bip_pkg::DP_CAP_CL;
                n_state = bip_pkg::S_SAMPLE;
            end
            bip_pkg::S_Y0_RD: begin
                o_op    = bip_pkg::DP_RD_Y0;
                n_state = bip_pkg::S_Y1_RD;
            end
            bip_pkg::S_Y1_RD: begin
                o_op    = bip_pkg::DP_RD_Y1;
                n_state = bip_pkg::S_PMUL;
            end
            bip_pkg::S_PMUL: begin
                o_op    = bip_pkg::DP_PMUL;
                n_state = bip_pkg::S_DIV_GO;
            end
            bip_pkg::S_DIV_GO: begin
                o_op    = bip_pkg::DP_QDIV;
                n_state = bip_pkg::S_DIV_W;
            end
            bip_pkg::S_DIV_W: begin
                if (i_sts.div_done) begin
                    o_op    = bip_pkg::DP_QTAKE;
                    n_state = bip_pkg::S_SAMPLE;
                end
            end
            bip_pkg::S_SAMPLE: begin
                if (i_sts.opcode == bip_pkg::OPC_QUERY) begin
                    n_state = bip_pkg::S_EMIT_Q;
                end else if (i_sts.k_zero) begin
                    o_op    = bip_pkg::DP_FIRST;
                    n_state = bip_pkg::S_POS_DIV;
                end else begin
                    n_state = bip_pkg::S_EMIT_P;
                end
            end
            bip_pkg::S_POS_DIV: begin
                o_op    = bip_pkg::DP_POS_DIV;
                n_state = bip_pkg::S_POS_W;
            end
            bip_pkg::S_POS_W: begin
                if (i_sts.div_done) begin
                    o_op    = bip_pkg::DP_POS_TAKE;
                    n_state = bip_pkg::S_RD_XMAX;
                end
            end
            bip_pkg::S_EMIT_OK: begin
                if (i_sts.out_free) begin
                    o_op    = bip_pkg::DP_EMIT_OK;
                    n_state = bip_pkg::S_IDLE;
                end
            end
            bip_pkg::S_EMIT_BAD: begin
                if (i_sts.out_free) begin
                    o_op    = bip_pkg::DP_EMIT_BAD;
                    n_state = bip_pkg::S_IDLE;
                end
            end
            bip_pkg::S_EMIT_Q: begin
                if (i_sts.out_free) begin
                    o_op    = bip_pkg::DP_EMIT_Q;
                    n_state = bip_pkg::S_IDLE;
                end
            end
            bip_pkg::S_EMIT_P: begin
                if (i_sts.out_free) begin
                    o_op    = bip_pkg::DP_EMIT_P;
                    n_state = i_sts.k_last ? bip_pkg::S_IDLE : bip_pkg::S_POS_DIV;
                end
            end
            default: n_state = bip_pkg::S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/bip_dp.sv =====
// ---------------------------------------------------------------------------
// bip_dp
// Datapath: breakpoint memories, search, multiply, divide and result register.
// ---------------------------------------------------------------------------
`default_nettype none

module bip_dp #(
    parameter int MAX_POINTS = bip_pkg::MAX_POINTS_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire bip_pkg::t_dp_op  i_op,
    output bip_pkg::t_dp_sts      o_sts,
    input  wire logic [63:0]      i_in_data,
    input  wire logic [1:0]       i_in_user,
    input  wire logic             i_cfg_valid,
    input  wire logic [6:0]       i_cfg_data,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output logic [23:0]           o_out_data,
    output logic                  o_out_last
);

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);

    logic [15:0] x_mem [MAX_POINTS];
    logic [15:0] y_mem [MAX_POINTS];

    logic [6:0]        r_point_count;
    bip_pkg::t_opcode  r_opcode;
    logic [5:0]        r_idx;
    logic [15:0]       r_px, r_py, r_qpos, r_pos;
    logic [6:0]        r_n, r_k;
    logic [15:0]       r_x_rd, r_y_rd, r_x0, r_x1;
    logic signed [15:0] r_y0, r_cur, r_prev;
    logic              r_cl, r_prev_cl, r_neg;
    logic [31:0]       r_scaled;
    logic [CW-1:0]     r_i;
    logic signed [49:0] r_prod;

    logic              r_out_valid, r_out_rise, r_out_last;
    logic [15:0]       r_out_y;
    logic [1:0]        r_out_st;

    logic [CW-1:0]     cnt;
    logic [AW-1:0]     x_addr, y_addr;
    logic signed [16:0] dy;
    logic signed [32:0] num;
    logic signed [49:0] prod;
    logic signed [33:0] shq;
    logic [33:0]       mag, qadj, qsig;
    logic [7:0]        n_plus;
    logic              div_start, div_done;
    logic [bip_pkg::DIV_W-1:0] div_dvd, div_quo;
    logic [bip_pkg::DVS_W-1:0] div_dvs, div_rem;
    logic              out_free;

    // Clamp the active point count into [2, MAX_POINTS]
    always_comb begin
        if (r_point_count < 7'd2) begin
            cnt = CW'(2);
        end else if (32'(r_point_count) > MAX_POINTS) begin
            cnt = CW'(MAX_POINTS);
        end else begin
            cnt = CW'(r_point_count);
        end
    end

    always_comb begin
        case (i_op)
            bip_pkg::DP_RD_XMAX: x_addr = AW'(cnt - 1'b1);
            default:             x_addr = AW'(r_i);
        endcase
        case (i_op)
            bip_pkg::DP_RD_YCL: y_addr = (r_i == '0) ? '0 : AW'(cnt - 1'b1);
            bip_pkg::DP_RD_Y0:  y_addr = AW'(r_i - 1'b1);
            default:            y_addr = AW'(r_i);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_op == bip_pkg::DP_WRITE) begin
            x_mem[AW'(r_idx)] <= r_px;
            y_mem[AW'(r_idx)] <= r_py;
        end
        r_x_rd <= x_mem[x_addr];
        r_y_rd <= y_mem[y_addr];
    end

    // Interpolation arithmetic
    always_comb begin
        dy   = $signed({r_y_rd[15], r_y_rd}) - $signed({r_y0[15], r_y0});
        num  = $signed({1'b0, r_scaled - {r_x0, 16'h0000}});
        prod = dy * num;
        shq  = r_prod[49:16];
        mag  = shq[33] ? 34'(-shq) : 34'(shq);
        qadj = div_quo + {33'b0, (div_rem != '0)};
        qsig = r_neg ? 34'(-qadj) : div_quo;
        n_plus = {1'b0, r_n} + 8'd1;
    end

    assign div_start = (i_op == bip_pkg::DP_QDIV) || (i_op == bip_pkg::DP_POS_DIV);
    assign div_dvd   = (i_op == bip_pkg::DP_QDIV) ? mag : {11'b0, r_k, 16'h0000};
    assign div_dvs   = (i_op == bip_pkg::DP_QDIV) ? (r_x1 - r_x0) : {8'b0, n_plus};

    bip_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_done     (div_done),
        .o_quo      (div_quo),
        .o_rem      (div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count <= bip_pkg::PC_RESET;
        end else if (i_cfg_valid) begin
            r_point_count <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_op)
            bip_pkg::DP_LOAD: begin
                r_opcode <= bip_pkg::t_opcode'(i_in_user);
                r_idx    <= i_in_data[5:0];
                r_px     <= i_in_data[21:6];
                r_py     <= i_in_data[37:22];
                r_qpos   <= i_in_data[53:38];
                r_n      <= i_in_data[60:54];
            end
            bip_pkg::DP_POS_INIT: begin
                r_pos <= (r_opcode == bip_pkg::OPC_QUERY) ? r_qpos : 16'h0000;
                r_k   <= '0;
            end
            bip_pkg::DP_MUL: begin
                r_scaled <= r_pos * r_x_rd;
                r_i      <= '0;
            end
            bip_pkg::DP_CHK_X: begin
                if ({r_x_rd, 16'h0000} > r_scaled) begin
                    r_x1 <= r_x_rd;
                end else begin
                    r_x0 <= r_x_rd;
                    r_i  <= r_i + 1'b1;
                end
            end
            bip_pkg::DP_CAP_CL: begin
                r_cur <= r_y_rd;
                r_cl  <= 1'b1;
            end
            bip_pkg::DP_RD_Y1: r_y0 <= r_y_rd;
            bip_pkg::DP_PMUL: begin
                r_prod <= prod;
                r_neg  <= prod[49];
            end
            bip_pkg::DP_QTAKE: begin
                r_cur <= r_y0 + $signed(qsig[15:0]);
                r_cl  <= 1'b0;
            end
            bip_pkg::DP_FIRST: begin
                r_prev    <= r_cur;
                r_prev_cl <= r_cl;
                r_k       <= 7'd1;
            end
            bip_pkg::DP_POS_TAKE: r_pos <= div_quo[15:0];
            bip_pkg::DP_EMIT_P: begin
                r_prev    <= r_cur;
                r_prev_cl <= r_cl;
                r_k       <= r_k + 1'b1;
            end
            default: ;
        endcase
    end

    // Result register: load a new item while the old one drains
    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            case (i_op)
                bip_pkg::DP_EMIT_OK, bip_pkg::DP_EMIT_BAD,
                bip_pkg::DP_EMIT_Q, bip_pkg::DP_EMIT_P: r_out_valid <= 1'b1;
                default: if (i_out_ready) r_out_valid <= 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_op)
            bip_pkg::DP_EMIT_OK, bip_pkg::DP_EMIT_BAD: begin
                r_out_y    <= '0;
                r_out_rise <= 1'b0;
                r_out_st   <= (i_op == bip_pkg::DP_EMIT_OK) ? bip_pkg::ST_OK : bip_pkg::ST_BAD;
                r_out_last <= 1'b1;
            end
            bip_pkg::DP_EMIT_Q: begin
                r_out_y    <= r_cur;
                r_out_rise <= 1'b0;
                r_out_st   <= r_cl ? bip_pkg::ST_CLAMP : bip_pkg::ST_OK;
                r_out_last <= 1'b1;
            end
            bip_pkg::DP_EMIT_P: begin
                r_out_y    <= '0;
                r_out_rise <= (r_cur > r_prev);
                r_out_st   <= (r_cl || r_prev_cl) ? bip_pkg::ST_CLAMP : bip_pkg::ST_OK;
                r_out_last <= (r_k == r_n);
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = {5'b0, r_out_st, r_out_rise, r_out_y};
    assign o_out_last  = r_out_last;

    always_comb begin
        o_sts.opcode   = r_opcode;
        o_sts.bad_idx  = (32'(r_idx) >= MAX_POINTS);
        o_sts.bad_cnt  = (r_n == '0) || (32'(r_n) > bip_pkg::MAX_PROFILE);
        o_sts.above    = ({r_x_rd, 16'h0000} > r_scaled);
        o_sts.i_zero   = (r_i == '0);
        o_sts.i_last   = (r_i == cnt - 1'b1);
        o_sts.div_done = div_done;
        o_sts.k_zero   = (r_k == '0);
        o_sts.k_last   = (r_k == r_n);
        o_sts.out_free = out_free;
    end

endmodule

`default_nettype wire
